### hdl/ism_pkg.sv
// Shared types and constants for the integer set median block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ism_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_SAMPLES_DFLT = 64;
	localparam int SAMPLE_BITS_DFLT = 32;

	// Fixed port field widths
	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;
	localparam int COUNT_W  = 7;

	// Commands broadcast from the controller to every cell
	typedef struct packed {
		logic insert;  // place the request sample into the sorted row
		logic shift;   // advance the row one cell toward the head
	} ism_ctrl_t;

endpackage

`default_nettype wire

### hdl/ism_in_if.sv
// Input channel of the integer set median block: valid/ready plus payload.
// Depends on ism_pkg for field widths.
`default_nettype none

interface ism_in_if;
	import ism_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       carries_sample;
	logic                       last;

	modport source (output valid, output sample, output carries_sample, output last,
		input ready);
	modport sink (input valid, input sample, input carries_sample, input last,
		output ready);

endinterface

`default_nettype wire

### hdl/ism_out_if.sv
// Result channel of the integer set median block: valid/ready plus payload.
// Depends on ism_pkg for field widths.
`default_nettype none

interface ism_out_if;
	import ism_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [MEDIAN_W-1:0] median_doubled;
	logic        [COUNT_W-1:0]  set_count;
	logic                       overflow;

	modport source (output valid, output median_doubled, output set_count,
		output overflow, input ready);
	modport sink (input valid, input median_doubled, input set_count,
		input overflow, output ready);

endinterface

`default_nettype wire

### hdl/ism_cell.sv
// One cell of the sorted insertion row: holds one sample.
// Depends on ism_pkg for the control struct.
`default_nettype none

module ism_cell import ism_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DFLT
) (
	input  wire logic                   clk,
	input  wire ism_ctrl_t              ctrl,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic                   occupied,
	input  wire logic [SAMPLE_BITS-1:0] left_val,
	input  wire logic                   left_gt,
	input  wire logic [SAMPLE_BITS-1:0] right_val,
	output logic                        gt,
	output logic      [SAMPLE_BITS-1:0] val
);

	logic [SAMPLE_BITS-1:0] val_q;

	// An empty cell counts as larger than any sample
	assign gt  = !occupied || ($signed(val_q) > $signed(sample));
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= right_val;
		end else if (ctrl.insert && gt) begin
			// take the left neighbor if it moves too, otherwise the new sample
			val_q <= left_gt ? left_val : sample;
		end
	end

endmodule

`default_nettype wire

### hdl/ism_chain.sv
// Row of insertion cells kept in ascending order, head at cell 0.
// Depends on ism_pkg and ism_cell.
`default_nettype none

module ism_chain import ism_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DFLT,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DFLT,
	localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
	input  wire logic                   clk,
	input  wire ism_ctrl_t              ctrl,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic [CW-1:0]          count,
	output logic      [SAMPLE_BITS-1:0] head0,
	output logic      [SAMPLE_BITS-1:0] head1
);

	logic [SAMPLE_BITS-1:0] val [MAX_SAMPLES];
	logic                   gt  [MAX_SAMPLES];

	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] left_val;
		logic                   left_gt;
		logic [SAMPLE_BITS-1:0] right_val;

		if (i == 0) begin : g_head
			assign left_val = sample;
			assign left_gt  = 1'b0;
		end else begin : g_body
			assign left_val = val[i-1];
			assign left_gt  = gt[i-1];
		end

		if (i == MAX_SAMPLES - 1) begin : g_tail
			assign right_val = val[i];
		end else begin : g_inner
			assign right_val = val[i+1];
		end

		ism_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.sample   (sample),
			.occupied (CW'(i) < count),
			.left_val (left_val),
			.left_gt  (left_gt),
			.right_val(right_val),
			.gt       (gt[i]),
			.val      (val[i])
		);
	end

	assign head0 = val[0];
	assign head1 = val[1];

endmodule

`default_nettype wire

### hdl/integer_set_median.sv
// Drain: a closing request starts the drain; the row shifts toward its head until the
//   middle is at the head, then the result enters the output register once the slot is free.
// Throughput: one sample request per cycle into the insertion row; the row drains
//   toward its head to reach the middle, and takes no request until the result is loaded.
// Reset (arst_n low): clears the count, the overflow flag, the state and the result valid;
//   sample cells are not cleared, the count marks which ones hold data.
`default_nettype none

module integer_set_median import ism_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DFLT,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DFLT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ism_in_if.sink    samples,
	ism_out_if.source result
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);

	typedef enum logic {ST_FILL, ST_DRAIN} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic                   ovf_q;
	logic [CW-1:0]          shifts_q;
	logic                   out_valid_q;
	logic [MEDIAN_W-1:0]    median_q;
	logic [COUNT_W-1:0]     set_count_q;
	logic                   out_ovf_q;

	ism_ctrl_t              ctrl;
	logic [SAMPLE_BITS-1:0] sample_bits;
	logic [SAMPLE_BITS-1:0] head0;
	logic [SAMPLE_BITS-1:0] head1;

	logic                   accept;
	logic                   room;
	logic                   do_insert;
	logic [CW-1:0]          count_next;
	logic [CW-1:0]          shifts_init;
	logic                   load_out;
	logic [MEDIAN_W-1:0]    head0_ext;
	logic [MEDIAN_W-1:0]    head1_ext;
	logic [MEDIAN_W-1:0]    median_next;

	// Only the low SAMPLE_BITS of a sample take part
	assign sample_bits = samples.sample[SAMPLE_BITS-1:0];

	assign samples.ready = (state_q == ST_FILL);
	assign accept        = samples.valid && samples.ready;
	assign room          = count_q < CW'(MAX_SAMPLES);
	assign do_insert     = accept && samples.carries_sample && room;
	assign count_next    = count_q + CW'(do_insert);

	// Shifts needed to bring the middle element (odd count) or the lower middle
	// element (even count) to the head of the row
	always_comb begin
		if (count_next == '0) begin
			shifts_init = '0;
		end else if (count_next[0]) begin
			shifts_init = count_next >> 1;
		end else begin
			shifts_init = (count_next >> 1) - CW'(1);
		end
	end

	assign ctrl.insert = do_insert;
	assign ctrl.shift  = (state_q == ST_DRAIN) && (shifts_q != '0);

	ism_chain #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_chain (
		.clk   (clk),
		.ctrl  (ctrl),
		.sample(sample_bits),
		.count (count_q),
		.head0 (head0),
		.head1 (head1)
	);

	// Sign-extend the head cells to the result width; the doubled value fits
	assign head0_ext = {{(MEDIAN_W - SAMPLE_BITS){head0[SAMPLE_BITS-1]}}, head0};
	assign head1_ext = {{(MEDIAN_W - SAMPLE_BITS){head1[SAMPLE_BITS-1]}}, head1};

	always_comb begin
		if (count_q == '0) begin
			median_next = '0;
		end else if (count_q[0]) begin
			median_next = head0_ext + head0_ext;
		end else begin
			median_next = head0_ext + head1_ext;
		end
	end

	// Load the result once the middle is at the head and the output slot is free
	assign load_out = (state_q == ST_DRAIN) && (shifts_q == '0)
		&& (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			shifts_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the taken result unless a new one replaces it
			if (result.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					if (accept) begin
						count_q <= count_next;
						if (samples.carries_sample && !room) begin
							ovf_q <= 1'b1;
						end
						if (samples.last) begin
							shifts_q <= shifts_init;
							state_q  <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (shifts_q != '0) begin
						// advance the row one cell toward the head
						shifts_q <= shifts_q - CW'(1);
					end else if (load_out) begin
						// hand off the result and open the next set
						out_valid_q <= 1'b1;
						count_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	// Result payload: no reset needed
	always_ff @(posedge clk) begin
		if (load_out) begin
			median_q    <= median_next;
			set_count_q <= COUNT_W'(count_q);
			out_ovf_q   <= ovf_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.median_doubled = median_q;
	assign result.set_count      = set_count_q;
	assign result.overflow       = out_ovf_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SAMPLES))
		else $error("kept count above capacity");

	a_shift_only_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(shifts_q != '0) |-> (state_q == ST_DRAIN))
		else $error("row shift pending outside drain");

	a_close_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready && samples.last) |=> !samples.ready)
		else $error("request taken right after a closing request");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.overflow) |-> (result.set_count == COUNT_W'(MAX_SAMPLES)))
		else $error("overflow reported with a store that was not full");
`endif

endmodule

`default_nettype wire
